// ===== rtl/thecd_pkg.sv =====
// Package for the cache directory: widths, opcodes, status codes and entry record.
// No dependencies.
package thecd_pkg;
	localparam int unsigned Entries = 64;
	localparam int unsigned IdxW = $clog2(Entries);
	localparam int unsigned CntW = $clog2(Entries + 1);
	localparam int unsigned UseBits = 24;
	localparam int unsigned KeyW = 64;
	localparam int unsigned EntW = KeyW + 32 + 32 + UseBits;

	localparam logic [2:0] OP_TICK = 3'd0;
	localparam logic [2:0] OP_GET = 3'd1;
	localparam logic [2:0] OP_PUT = 3'd2;
	localparam logic [2:0] OP_INVAL = 3'd3;
	localparam logic [2:0] OP_PURGE = 3'd4;

	localparam logic [2:0] ST_DONE = 3'd0;
	localparam logic [2:0] ST_HIT = 3'd1;
	localparam logic [2:0] ST_MISS_ABSENT = 3'd2;
	localparam logic [2:0] ST_MISS_EXPIRED = 3'd3;
	localparam logic [2:0] ST_STORED = 3'd4;
	localparam logic [2:0] ST_TOO_LARGE = 3'd5;

	localparam logic [0:0] CFG_SIZE_LIMIT = 1'b0;
	localparam logic [0:0] CFG_LIFETIME = 1'b1;

	typedef struct packed {
		logic [KeyW-1:0] key;
		logic [31:0] bytes;
		logic [31:0] expiry;
		logic [UseBits-1:0] uses;
	} entry_t;
endpackage

// ===== rtl/thecd_if.sv =====
// Channel interfaces for the cache directory: request, response and config write.
// No dependencies.
interface thecd_req_if;
	logic valid;
	logic ready;
	logic [2:0] opcode;
	logic [63:0] stripe_key;
	logic [31:0] entry_bytes;
	modport source(output valid, opcode, stripe_key, entry_bytes, input ready);
	modport sink(input valid, opcode, stripe_key, entry_bytes, output ready);
endinterface

interface thecd_rsp_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [5:0] slot;
	logic [31:0] found_bytes;
	logic [6:0] evicted_count;
	logic [31:0] bytes_in_use;
	logic [31:0] hit_total;
	logic [31:0] miss_total;
	modport source(output valid, status, slot, found_bytes, evicted_count, bytes_in_use,
		hit_total, miss_total, input ready);
	modport sink(input valid, status, slot, found_bytes, evicted_count, bytes_in_use,
		hit_total, miss_total, output ready);
endinterface

interface thecd_cfg_if;
	logic valid;
	logic ready;
	logic [0:0] index;
	logic [31:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/thecd_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module thecd_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/ttl_heat_evict_cache_directory_core.sv =====
// Cache directory core: key table in one RAM, valid bits in flops, sequencer scans.
// A tick or an unused opcode answers without a table scan; a get, invalidate, purge or rejected
// put scans the table at most once, and a stored put scans it for the key, for expired entries
// and once more per heat or full-table eviction; each table scan goes through the one RAM read
// port. One item at a time; the next request beat can be taken in the cycle after the response.
// Reset clears valid bits, counters and config to defaults. Depends on thecd_pkg, thecd_if, thecd_ram.
module ttl_heat_evict_cache_directory_core (
	input logic clk,
	input logic arst_n,
	thecd_req_if.sink req,
	thecd_rsp_if.source rsp,
	thecd_cfg_if.sink cfg
);
	import thecd_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_FIND, S_GETRD, S_GETWB, S_PUTCHK, S_PURGE, S_COOL, S_FREE, S_WRITE, S_RESP
	} state_t;

	state_t state_q;
	logic [31:0] size_limit_q, now_q, used_q, hits_q, miss_q;
	logic [19:0] life_q;
	logic [Entries-1:0] valid_q;
	logic [2:0] op_q, status_q;
	logic [KeyW-1:0] key_q;
	logic [31:0] bytes_q, found_q;
	logic [IdxW-1:0] slot_q;
	logic [6:0] evict_q;
	logic [CntW-1:0] scan_q;
	logic hitf_q, best_vld_q;
	logic [IdxW-1:0] best_q;
	logic [63:0] best_s_q;
	logic [IdxW-1:0] rd_idx_s1;
	logic rd_vld_s1;

	logic we;
	logic [IdxW-1:0] waddr, raddr;
	entry_t wdata, rdata;

	thecd_ram #(.Width(EntW), .Depth(Entries)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// New expiry, saturated.
	logic [32:0] exp_sum;
	logic [31:0] new_exp;
	assign exp_sum = {1'b0, now_q} + {13'd0, life_q};
	assign new_exp = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];

	// Heat of the entry on the read port.
	logic [63:0] heat;
	logic [32:0] remain;
	assign remain = {1'b0, rdata.expiry - now_q} + 33'd1;
	assign heat = {{(32-UseBits){1'b0}}, rdata.uses} * remain[31:0]
		+ (remain[32] ? {{(32-UseBits){1'b0}}, rdata.uses, 32'd0} : 64'd0);
	logic expired_rd;
	assign expired_rd = now_q > rdata.expiry;
	logic rd_live;
	assign rd_live = rd_vld_s1 && valid_q[rd_idx_s1];

	// Lowest free slot.
	logic [IdxW-1:0] free_idx;
	logic any_free;
	always_comb begin
		free_idx = '0;
		any_free = 1'b0;
		for (int i = Entries - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IdxW'(i);
				any_free = 1'b1;
			end
		end
	end

	logic [32:0] need;
	assign need = {1'b0, used_q} + {1'b0, bytes_q};

	assign raddr = scan_q[IdxW-1:0];
	assign req.ready = state_q == S_IDLE;
	assign cfg.ready = state_q == S_IDLE;
	assign rsp.valid = state_q == S_RESP;
	assign rsp.status = status_q;
	assign rsp.slot = 6'(slot_q);
	assign rsp.found_bytes = found_q;
	assign rsp.evicted_count = evict_q;
	assign rsp.bytes_in_use = used_q;
	assign rsp.hit_total = hits_q;
	assign rsp.miss_total = miss_q;

	// Write port: get renewal or put insert.
	always_comb begin
		we = 1'b0;
		waddr = slot_q;
		wdata = rdata;
		if (state_q == S_GETWB) begin
			we = 1'b1;
			wdata.expiry = new_exp;
			if (rdata.uses != {UseBits{1'b1}}) begin
				wdata.uses = rdata.uses + UseBits'(1);
			end
		end else if (state_q == S_WRITE) begin
			we = 1'b1;
			waddr = free_idx;
			wdata.key = key_q;
			wdata.bytes = bytes_q;
			wdata.expiry = new_exp;
			wdata.uses = UseBits'(1);
		end
	end

	// Sequencer with counters and registered response.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			size_limit_q <= 32'd268435456;
			life_q <= 20'd3600;
			now_q <= '0;
			used_q <= '0;
			hits_q <= '0;
			miss_q <= '0;
			valid_q <= '0;
			scan_q <= '0;
			rd_vld_s1 <= 1'b0;
			op_q <= OP_TICK;
			status_q <= ST_DONE;
			slot_q <= '0;
			found_q <= '0;
			evict_q <= '0;
			hitf_q <= 1'b0;
			best_vld_q <= 1'b0;
		end else begin
			rd_idx_s1 <= raddr;
			rd_vld_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cfg.valid) begin
						if (cfg.index == CFG_SIZE_LIMIT) size_limit_q <= cfg.data;
						else life_q <= cfg.data[19:0];
					end
					if (req.valid) begin
						op_q <= req.opcode;
						key_q <= req.stripe_key;
						bytes_q <= req.entry_bytes;
						status_q <= ST_DONE;
						slot_q <= '0;
						found_q <= '0;
						evict_q <= '0;
						hitf_q <= 1'b0;
						scan_q <= '0;
						rd_vld_s1 <= 1'b0;
						if (req.opcode == OP_TICK) begin
							if (now_q != 32'hFFFF_FFFF) now_q <= now_q + 32'd1;
							state_q <= S_RESP;
						end else if (req.opcode == OP_PURGE) begin
							state_q <= S_PURGE;
						end else if (req.opcode == OP_GET || req.opcode == OP_PUT
							|| req.opcode == OP_INVAL) begin
							state_q <= S_FIND;
						end else begin
							state_q <= S_RESP;
						end
					end
				end
				S_FIND: begin
					// Stream reads; compare each entry in the cycle after its read.
					if (scan_q < CntW'(Entries)) begin
						scan_q <= scan_q + CntW'(1);
						rd_vld_s1 <= 1'b1;
					end
					if (rd_live && !hitf_q && rdata.key == key_q) begin
						hitf_q <= 1'b1;
						slot_q <= rd_idx_s1;
						if (op_q == OP_GET) begin
							if (expired_rd) begin
								valid_q[rd_idx_s1] <= 1'b0;
								used_q <= used_q - rdata.bytes;
								evict_q <= 7'd1;
								status_q <= ST_MISS_EXPIRED;
								slot_q <= '0;
								if (miss_q != 32'hFFFF_FFFF) miss_q <= miss_q + 32'd1;
								state_q <= S_RESP;
							end else begin
								status_q <= ST_HIT;
								found_q <= rdata.bytes;
								if (hits_q != 32'hFFFF_FFFF) hits_q <= hits_q + 32'd1;
								scan_q <= {1'b0, rd_idx_s1};
								state_q <= S_GETRD;
							end
						end else if (op_q == OP_INVAL) begin
							valid_q[rd_idx_s1] <= 1'b0;
							used_q <= used_q - rdata.bytes;
							evict_q <= 7'd1;
							state_q <= S_RESP;
						end else begin
							valid_q[rd_idx_s1] <= 1'b0;
							used_q <= used_q - rdata.bytes;
							slot_q <= '0;
							state_q <= S_PUTCHK;
						end
					end else if (!rd_vld_s1 && scan_q == CntW'(Entries)) begin
						if (op_q == OP_GET) begin
							status_q <= ST_MISS_ABSENT;
							if (miss_q != 32'hFFFF_FFFF) miss_q <= miss_q + 32'd1;
							state_q <= S_RESP;
						end else if (op_q == OP_PUT) begin
							state_q <= S_PUTCHK;
						end else begin
							state_q <= S_RESP;
						end
					end
				end
				S_GETRD: begin
					// The hit slot is on the read address; its entry arrives next cycle.
					state_q <= S_GETWB;
				end
				S_GETWB: begin
					// Read of the hit slot is on rdata now; write the renewal.
					state_q <= S_RESP;
				end
				S_PUTCHK: begin
					scan_q <= '0;
					if (bytes_q > size_limit_q) begin
						status_q <= ST_TOO_LARGE;
						state_q <= S_RESP;
					end else begin
						state_q <= S_PURGE;
					end
				end
				S_PURGE: begin
					if (scan_q < CntW'(Entries)) begin
						scan_q <= scan_q + CntW'(1);
						rd_vld_s1 <= 1'b1;
					end
					if (rd_live && expired_rd) begin
						valid_q[rd_idx_s1] <= 1'b0;
						used_q <= used_q - rdata.bytes;
						evict_q <= evict_q + 7'd1;
					end
					if (!rd_vld_s1 && scan_q == CntW'(Entries)) begin
						scan_q <= '0;
						best_vld_q <= 1'b0;
						state_q <= op_q == OP_PUT ? S_FREE : S_RESP;
					end
				end
				S_FREE: begin
					// Decide: evict for size, evict for a full table, or insert.
					scan_q <= '0;
					best_vld_q <= 1'b0;
					if ((need > {1'b0, size_limit_q} && valid_q != '0) || !any_free) begin
						state_q <= S_COOL;
					end else begin
						state_q <= S_WRITE;
					end
				end
				S_COOL: begin
					if (scan_q < CntW'(Entries)) begin
						scan_q <= scan_q + CntW'(1);
						rd_vld_s1 <= 1'b1;
					end
					if (rd_live && (!best_vld_q || heat < best_s_q)) begin
						best_vld_q <= 1'b1;
						best_q <= rd_idx_s1;
						best_s_q <= heat;
						found_q <= rdata.bytes;
					end
					if (!rd_vld_s1 && scan_q == CntW'(Entries)) begin
						valid_q[best_q] <= 1'b0;
						used_q <= used_q - found_q;
						found_q <= '0;
						evict_q <= evict_q + 7'd1;
						state_q <= S_FREE;
					end
				end
				S_WRITE: begin
					valid_q[free_idx] <= 1'b1;
					used_q <= used_q + bytes_q;
					slot_q <= free_idx;
					status_q <= ST_STORED;
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (rsp.ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !req.ready) else $error("accept while busy");
	a_tick_mono: assert property (@(posedge clk) disable iff (!arst_n)
		now_q >= $past(now_q)) else $error("tick went back");
	a_store_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && status_q == ST_STORED |-> valid_q[slot_q]) else $error("stored slot invalid");
	a_hit_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && status_q != ST_HIT |-> found_q == '0) else $error("found bytes not zero");
`endif
endmodule

// ===== verif/tb_ttl_heat_evict_cache_directory_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the TTL cache directory core: directed and random operations
// with random handshake gaps, checked against an in-bench model of the directory.
// Depends on thecd_pkg, thecd_if and the core RTL.
module tb_ttl_heat_evict_cache_directory_core;
	import thecd_pkg::*;

	localparam int unsigned NumSlots = 64;
	localparam int unsigned WatchLimit = 60000;
	localparam logic [31:0] Max32 = 32'hFFFF_FFFF;

	typedef struct {
		logic [2:0] opcode;
		logic [63:0] key;
		logic [31:0] nbytes;
	} op_item_t;

	typedef struct {
		logic [2:0] status;
		logic [5:0] slot;
		logic [31:0] found_bytes;
		logic [6:0] evicted_count;
		logic [31:0] bytes_in_use;
		logic [31:0] hit_total;
		logic [31:0] miss_total;
	} dir_result_t;

	logic clk;
	logic arst_n;

	thecd_req_if req();
	thecd_rsp_if rsp();
	thecd_cfg_if cfg();

	ttl_heat_evict_cache_directory_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg(cfg)
	);

	// Shadow copy of the directory state and registers.
	logic sh_valid [NumSlots];
	logic [63:0] sh_key [NumSlots];
	logic [31:0] sh_bytes [NumSlots];
	logic [31:0] sh_expiry [NumSlots];
	logic [UseBits-1:0] sh_uses [NumSlots];
	logic [31:0] sh_now, sh_used, sh_hits, sh_misses;
	logic [31:0] sh_limit;
	logic [19:0] sh_lifetime;

	op_item_t pending_ops[$];
	dir_result_t expected_results[$];

	int unsigned mismatches = 0;
	int unsigned ops_sent = 0;
	int unsigned results_seen = 0;
	int unsigned hits_seen = 0;
	int unsigned stores_seen = 0;
	int unsigned evictions_seen = 0;
	int unsigned idle_cycles = 0;
	logic long_hold = 1'b0;
	logic no_gaps = 1'b0;

	always #5 clk = ~clk;

	function automatic logic [31:0] fresh_expiry();
		logic [32:0] e;
		e = {1'b0, sh_now} + {13'b0, sh_lifetime};
		return e[32] ? Max32 : e[31:0];
	endfunction

	function automatic int find_slot(logic [63:0] key);
		for (int i = 0; i < NumSlots; i++)
			if (sh_valid[i] && sh_key[i] == key)
				return i;
		return -1;
	endfunction

	function automatic void drop_slot(int i);
		sh_valid[i] = 1'b0;
		sh_used = sh_used - sh_bytes[i];
	endfunction

	function automatic int purge_stale();
		int n;
		n = 0;
		for (int i = 0; i < NumSlots; i++)
			if (sh_valid[i] && sh_now > sh_expiry[i]) begin
				drop_slot(i);
				n++;
			end
		return n;
	endfunction

	// Lowest heat, uses * (expiry - now + 1); the lower slot wins a tie.
	function automatic int coolest_slot();
		int best;
		logic [63:0] best_heat, heat;
		best = -1;
		best_heat = '0;
		for (int i = 0; i < NumSlots; i++) begin
			if (!sh_valid[i])
				continue;
			heat = {40'b0, sh_uses[i]} * ({32'b0, sh_expiry[i] - sh_now} + 64'd1);
			if (best < 0 || heat < best_heat) begin
				best = i;
				best_heat = heat;
			end
		end
		return best;
	endfunction

	function automatic int first_free();
		for (int i = 0; i < NumSlots; i++)
			if (!sh_valid[i])
				return i;
		return NumSlots;
	endfunction

	function automatic dir_result_t apply_op(op_item_t it);
		dir_result_t r;
		int i, ev;
		r.status = ST_DONE;
		r.slot = '0;
		r.found_bytes = '0;
		ev = 0;
		case (it.opcode)
			OP_TICK: begin
				if (sh_now != Max32)
					sh_now++;
			end
			OP_GET: begin
				i = find_slot(it.key);
				if (i < 0) begin
					r.status = ST_MISS_ABSENT;
					if (sh_misses != Max32) sh_misses++;
				end else if (sh_now > sh_expiry[i]) begin
					drop_slot(i);
					ev = 1;
					r.status = ST_MISS_EXPIRED;
					if (sh_misses != Max32) sh_misses++;
				end else begin
					sh_expiry[i] = fresh_expiry();
					if (sh_uses[i] != '1) sh_uses[i]++;
					if (sh_hits != Max32) sh_hits++;
					r.status = ST_HIT;
					r.slot = i[5:0];
					r.found_bytes = sh_bytes[i];
				end
			end
			OP_PUT: begin
				i = find_slot(it.key);
				if (i >= 0)
					drop_slot(i);
				if (it.nbytes > sh_limit) begin
					r.status = ST_TOO_LARGE;
				end else begin
					ev = purge_stale();
					while ({1'b0, sh_used} + {1'b0, it.nbytes} > {1'b0, sh_limit}) begin
						i = coolest_slot();
						if (i < 0) break;
						drop_slot(i);
						ev++;
					end
					i = first_free();
					if (i >= NumSlots) begin
						drop_slot(coolest_slot());
						ev++;
						i = first_free();
					end
					sh_valid[i] = 1'b1;
					sh_key[i] = it.key;
					sh_bytes[i] = it.nbytes;
					sh_expiry[i] = fresh_expiry();
					sh_uses[i] = UseBits'(1);
					sh_used = sh_used + it.nbytes;
					r.status = ST_STORED;
					r.slot = i[5:0];
				end
			end
			OP_INVAL: begin
				i = find_slot(it.key);
				if (i >= 0) begin
					drop_slot(i);
					ev = 1;
					r.slot = i[5:0];
				end
			end
			OP_PURGE: ev = purge_stale();
			default: ;
		endcase
		r.evicted_count = ev[6:0];
		r.bytes_in_use = sh_used;
		r.hit_total = sh_hits;
		r.miss_total = sh_misses;
		return r;
	endfunction

	// Request driver: presents the head of the pending queue, with random gaps between beats.
	int unsigned req_gap = 0;
	always @(posedge clk) begin
		logic next_valid;
		op_item_t it;
		if (req.valid && req.ready) begin
			it = pending_ops.pop_front();
			expected_results = {expected_results, apply_op(it)};
			ops_sent++;
		end
		next_valid = 1'b0;
		if (req.valid && !req.ready) begin
			next_valid = 1'b1;
		end else if (req_gap > 0) begin
			req_gap--;
		end else if (pending_ops.size() > 0) begin
			next_valid = 1'b1;
			req.opcode <= pending_ops[0].opcode;
			req.stripe_key <= pending_ops[0].key;
			req.entry_bytes <= pending_ops[0].nbytes;
			if (!no_gaps && $urandom_range(0, 3) == 0)
				req_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) :
					$urandom_range(1, 3);
		end
		req.valid <= next_valid;
	end

	// Long receiver hold-off, counted here so the sender keeps offering meanwhile.
	int unsigned hold_count = 0;
	always @(posedge clk) begin
		if (long_hold && hold_count < 600) begin
			hold_count++;
		end else if (long_hold) begin
			long_hold <= 1'b0;
			hold_count = 0;
		end
	end

	// Response sink: random ready gaps, then compare each beat with the oldest expectation.
	int unsigned rsp_gap = 0;
	always @(posedge clk) begin
		dir_result_t want;
		logic next_ready;
		if (rsp.valid && rsp.ready) begin
			results_seen++;
			if (rsp.status == ST_HIT) hits_seen++;
			if (rsp.status == ST_STORED) stores_seen++;
			evictions_seen += rsp.evicted_count;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result beat, status %0d", rsp.status);
			end else begin
				want = expected_results.pop_front();
				if (rsp.status !== want.status || rsp.slot !== want.slot ||
						rsp.found_bytes !== want.found_bytes ||
						rsp.evicted_count !== want.evicted_count ||
						rsp.bytes_in_use !== want.bytes_in_use ||
						rsp.hit_total !== want.hit_total ||
						rsp.miss_total !== want.miss_total) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("ERROR: result %0d expected st %0d slot %0d found %0d ev %0d used %0d hits %0d misses %0d",
							results_seen, want.status, want.slot, want.found_bytes,
							want.evicted_count, want.bytes_in_use, want.hit_total,
							want.miss_total);
						$display("       actual st %0d slot %0d found %0d ev %0d used %0d hits %0d misses %0d",
							rsp.status, rsp.slot, rsp.found_bytes, rsp.evicted_count,
							rsp.bytes_in_use, rsp.hit_total, rsp.miss_total);
					end
				end
			end
		end
		next_ready = 1'b1;
		if (long_hold) begin
			next_ready = 1'b0;
		end else if (rsp_gap > 0) begin
			rsp_gap--;
			next_ready = 1'b0;
		end else if (!no_gaps && $urandom_range(0, 4) == 0) begin
			rsp_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) :
				$urandom_range(1, 3);
		end
		rsp.ready <= next_ready;
	end

	// Watchdog: ends the run when no beat moves for too long.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WatchLimit) begin
			$display("Timeout: no beat for %0d cycles", WatchLimit);
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic write_reg(logic [0:0] idx, logic [31:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx == CFG_SIZE_LIMIT)
			sh_limit = value;
		else
			sh_lifetime = value[19:0];
	endtask

	task automatic wait_drained();
		while (pending_ops.size() > 0 || expected_results.size() > 0 || req.valid)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic queue_op(logic [2:0] opcode, logic [63:0] key, logic [31:0] nbytes);
		op_item_t it;
		it.opcode = opcode;
		it.key = key;
		it.nbytes = nbytes;
		pending_ops = {pending_ops, it};
	endtask

	// Keys come mostly from a pool a little larger than the table, so hits and
	// full-table evictions both happen.
	function automatic logic [63:0] pick_key();
		logic [63:0] idx;
		if ($urandom_range(0, 9) == 0)
			return {$urandom, $urandom};
		idx = 64'($urandom_range(0, 71));
		return (idx + 64'd1) * 64'h9E37_79B9_7F4A_7C15;
	endfunction

	function automatic logic [31:0] pick_bytes();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel < 6)
			return $urandom_range(0, sh_limit / 16);
		else if (sel < 8)
			return $urandom_range(sh_limit / 2, sh_limit);
		else if (sel < 9 || sh_limit == Max32)
			return $urandom;
		else
			return sh_limit + 32'd1;
	endfunction

	task automatic queue_random(int unsigned count);
		int unsigned sel;
		logic [2:0] opcode;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 20) opcode = OP_TICK;
			else if (sel < 50) opcode = OP_GET;
			else if (sel < 80) opcode = OP_PUT;
			else if (sel < 90) opcode = OP_INVAL;
			else if (sel < 95) opcode = OP_PURGE;
			else opcode = 3'($urandom_range(5, 7));
			queue_op(opcode, pick_key(), pick_bytes());
		end
	endtask

	task automatic run_phase(logic [31:0] limit, logic [19:0] life, int unsigned count,
			logic calm, logic hold);
		wait_drained();
		write_reg(CFG_SIZE_LIMIT, limit);
		write_reg(CFG_LIFETIME, {12'b0, life});
		no_gaps = calm;
		queue_random(count);
		if (hold)
			long_hold <= 1'b1;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.opcode = OP_TICK;
		req.stripe_key = '0;
		req.entry_bytes = '0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = CFG_SIZE_LIMIT;
		cfg.data = '0;
		for (int i = 0; i < NumSlots; i++) begin
			sh_valid[i] = 1'b0;
			sh_key[i] = '0;
			sh_bytes[i] = '0;
			sh_expiry[i] = '0;
			sh_uses[i] = '0;
		end
		sh_now = '0;
		sh_used = '0;
		sh_hits = '0;
		sh_misses = '0;
		sh_limit = 32'd268435456;
		sh_lifetime = 20'd3600;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings, field extremes, rejection, exact fit, forced
		// eviction, invalidate of present and absent keys, unused opcodes.
		queue_op(OP_GET, 64'd0, 32'd0);
		queue_op(OP_PUT, 64'd0, 32'd0);
		queue_op(OP_PUT, '1, Max32);
		queue_op(OP_PUT, '1, 32'd268435456);
		queue_op(OP_GET, '1, 32'd0);
		queue_op(OP_PUT, 64'd0, 32'd1);
		queue_op(OP_INVAL, 64'd0, 32'd0);
		queue_op(OP_INVAL, 64'd0, 32'd0);
		queue_op(OP_PUT, 64'h5555_5555_5555_5555, 32'h00AA_AAAA);
		queue_op(OP_PUT, 64'h5555_5555_5555_5555, 32'h0055_5555);
		queue_op(OP_PURGE, '1, Max32);
		queue_op(OP_TICK, '1, Max32);
		queue_op(3'd5, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA);
		queue_op(3'd6, '1, Max32);
		queue_op(3'd7, 64'd0, 32'd0);
		wait_drained();

		// Directed: short lifetime for expired gets, purge on put and re-put of a key.
		write_reg(CFG_SIZE_LIMIT, 32'd1000);
		write_reg(CFG_LIFETIME, 32'd2);
		queue_op(OP_PUT, 64'd1, 32'd10);
		repeat (3) queue_op(OP_TICK, 64'd0, 32'd0);
		queue_op(OP_GET, 64'd1, 32'd0);
		queue_op(OP_PUT, 64'd2, 32'd5);
		repeat (3) queue_op(OP_TICK, 64'd0, 32'd0);
		queue_op(OP_PUT, 64'd3, 32'd5);
		queue_op(OP_PUT, 64'd3, 32'd7);
		queue_op(OP_PURGE, 64'd0, 32'd0);

		// Random phases across register settings, the extremes among them.
		run_phase(32'd268435456, 20'd3600, 300, 1'b0, 1'b0);
		run_phase(32'd1000, 20'd4, 300, 1'b0, 1'b1);
		run_phase(32'd0, 20'd0, 100, 1'b1, 1'b0);
		run_phase(Max32, 20'hFFFFF, 300, 1'b0, 1'b0);
		run_phase(32'd5000, 20'd30, 400, 1'b0, 1'b1);
		run_phase(32'd200, 20'd1, 250, 1'b0, 1'b0);
		wait_drained();
		repeat (200) @(posedge clk);

		$display("Ran %0d operations, directed cases and six random phases: %0d results, %0d hits,",
			ops_sent, results_seen, hits_seen);
		$display("%0d stores and %0d evictions; %0d mismatches.",
			stores_seen, evictions_seen, mismatches);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
